// ===== hdl/assert_macros.svh =====
// assertion macros shared by the odometry rtl
// expects clk and arst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error(msg);
`endif

// ===== hdl/ddo_pkg.sv =====
// shared types, constants and the arctangent table for the odometry core
// no dependencies
package ddo_pkg;

	localparam int ATAN_ENTRIES = 30;
	localparam logic [37:0] HALF_PI_Q30 = 38'd1686629713;
	localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;

	localparam logic [2:0] CFG_DUTY_THR  = 3'd0;
	localparam logic [2:0] CFG_SPEED_LIM = 3'd1;
	localparam logic [2:0] CFG_SPT       = 3'd2;
	localparam logic [2:0] CFG_RADIUS    = 3'd3;
	localparam logic [2:0] CFG_ROB       = 3'd4;
	localparam logic [2:0] CFG_TICK      = 3'd5;
	localparam logic [2:0] CFG_STEP_LIM  = 3'd6;

	typedef enum logic [2:0] {SH_0, SH_8, SH_16, SH_17, SH_50} shift_t;

	typedef struct packed {
		logic [63:0] a;
		logic [31:0] b;
		logic        neg;
		shift_t      sh;
	} mul_req_t;

	typedef struct packed {
		logic               ready;
		logic signed [33:0] cos_v;
		logic signed [33:0] sin_v;
	} trig_t;

	typedef enum logic [1:0] {TR_IDLE, TR_DIV, TR_ROT} trig_state_t;

	typedef enum logic [2:0] {ST_IDLE, ST_GO, ST_WAIT, ST_CHECK, ST_DONE} state_t;

	typedef enum logic [3:0] {
		OP_ENC_L, OP_ENC_R, OP_V, OP_D, OP_RATE, OP_DTH, OP_DX, OP_DY, OP_SQX, OP_SQY
	} op_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000007;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/ddo_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// final shift, 64-bit saturation and sign; depends on ddo_pkg
`include "assert_macros.svh"
module ddo_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ddo_pkg::mul_req_t   req,
	output logic                done,
	output logic signed [63:0]  result
);
	import ddo_pkg::*;

	localparam int BW = 32;
	localparam int CW = $clog2(BW);

	logic          busy_q, fin_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]   a_q, hi_q;
	logic [BW-1:0] lo_q;
	logic          neg_q;
	shift_t        sh_q;
	logic signed [63:0] res_q;

	logic [64:0] sum;
	logic [95:0] prod, shifted;
	logic [62:0] mag63;

	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 65'd0);
	assign prod = {hi_q, lo_q};

	always_comb begin
		case (sh_q)
			SH_0:    shifted = prod;
			SH_8:    shifted = prod >> 8;
			SH_16:   shifted = prod >> 16;
			SH_17:   shifted = prod >> 17;
			SH_50:   shifted = prod >> 50;
			default: shifted = prod;
		endcase
	end

	assign mag63 = (|shifted[95:63]) ? {63{1'b1}} : shifted[62:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {CW{1'b1}}) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= req.a;
			hi_q  <= '0;
			lo_q  <= req.b;
			neg_q <= req.neg;
			sh_q  <= req.sh;
		end else if (busy_q) begin
			hi_q <= sum[64:1];
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end else if (fin_q) begin
			res_q <= neg_q ? 64'sd0 - $signed({1'b0, mag63}) : $signed({1'b0, mag63});
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`CHK_ALWAYS(a_mul_start_free, start |-> (!busy_q && !fin_q), "multiply started while busy")
	`CHK_NEXT(a_mul_done_pulse, done_q, !done_q, "done held longer than one cycle")

endmodule

// ===== hdl/ddo_cordic.sv =====
// heading to cos and sin: serial quarter-turn division then iterative cordic
// one quotient bit or one rotation per cycle; depends on ddo_pkg
`include "assert_macros.svh"
module ddo_cordic #(
	parameter int TRIG_ITERATIONS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] heading,
	output ddo_pkg::trig_t     trig
);
	import ddo_pkg::*;

	localparam int STEPS = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
	localparam int IW = $clog2(STEPS);

	trig_state_t st_q, st_nx;
	logic [37:0] rem_q;
	logic [6:0]  quo_q;
	logic [2:0]  k_q;
	logic        neg_q, ready_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [IW-1:0] i_q;
	logic [1:0]  quad_q;

	logic signed [37:0] ang;
	logic [37:0] ang_mag, trial, rem_nx;
	logic        ge;
	logic [6:0]  quo_nx, quo_neg;
	logic signed [33:0] z_pos, xs, ys, at;
	logic [4:0]  i_idx;

	assign ang     = {heading, 6'd0};
	assign ang_mag = ang[37] ? 38'd0 - ang : ang;
	assign trial   = HALF_PI_Q30 << k_q;
	assign ge      = rem_q >= trial;
	assign rem_nx  = ge ? rem_q - trial : rem_q;
	assign quo_nx  = {quo_q[5:0], ge};
	assign quo_neg = 7'd0 - quo_nx;
	assign z_pos   = $signed(rem_nx[33:0]);
	assign i_idx   = 5'(i_q);
	assign xs      = x_q >>> i_q;
	assign ys      = y_q >>> i_q;
	assign at      = $signed({2'b00, atan_entry(i_idx)});

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			TR_IDLE: if (start) st_nx = TR_DIV;
			TR_DIV:  if (k_q == 3'd0) st_nx = TR_ROT;
			TR_ROT:  if (i_q == IW'(STEPS - 1)) st_nx = TR_IDLE;
			default: st_nx = TR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= TR_IDLE;
			ready_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (start)
				ready_q <= 1'b0;
			else if (st_q == TR_ROT && st_nx == TR_IDLE)
				ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ang_mag;
			neg_q <= ang[37];
			quo_q <= '0;
			k_q   <= 3'd6;
		end else if (st_q == TR_DIV) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			k_q   <= k_q - 1'b1;
			if (k_q == 3'd0) begin
				z_q    <= neg_q ? 34'sd0 - z_pos : z_pos;
				quad_q <= neg_q ? quo_neg[1:0] : quo_nx[1:0];
				x_q    <= INV_GAIN_Q30;
				y_q    <= '0;
				i_q    <= '0;
			end
		end else if (st_q == TR_ROT) begin
			i_q <= i_q + 1'b1;
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		trig.ready = ready_q;
		case (quad_q)
			2'd0: begin trig.cos_v = x_q;         trig.sin_v = y_q;         end
			2'd1: begin trig.cos_v = 34'sd0 - y_q; trig.sin_v = x_q;         end
			2'd2: begin trig.cos_v = 34'sd0 - x_q; trig.sin_v = 34'sd0 - y_q; end
			default: begin trig.cos_v = y_q;      trig.sin_v = 34'sd0 - x_q; end
		endcase
	end

	`CHK_ALWAYS(a_trig_start_idle, start |-> (st_q == TR_IDLE), "cordic restarted mid-run")
	`CHK_ALWAYS(a_trig_ready_idle, ready_q |-> (st_q == TR_IDLE), "ready while running")

endmodule

// ===== hdl/diff_drive_odometry_core.sv =====
// a reset-pose request goes straight to the done state; a tick request runs ten products
// through one bit-serial multiplier, then the step check, then the done state
// throughput: one request at a time; a new request is taken while the result waits
// reset: config registers to defaults, pose, held speeds and last counts to zero
// depends on ddo_pkg, ddo_mul, ddo_cordic
`include "assert_macros.svh"
module diff_drive_odometry_core #(
	parameter int COUNT_WIDTH     = 32,
	parameter int TRIG_ITERATIONS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic signed [31:0] left_measured,
	input  logic signed [31:0] right_measured,
	input  logic [9:0]         left_duty,
	input  logic [9:0]         right_duty,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading_out,
	output logic signed [31:0] right_rate,
	output logic signed [31:0] left_rate,
	output logic               step_accepted,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ddo_pkg::*;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'd0 - v : v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] pick(input logic zero, input logic [9:0] duty,
			input logic [9:0] thr, input logic signed [31:0] meas,
			input logic [31:0] lim, input logic signed [31:0] enc);
		logic [32:0] mm;
		logic signed [31:0] r;
		mm = meas[31] ? 33'd0 - {1'b1, meas} : {1'b0, meas};
		if (zero)
			r = '0;
		else if (duty < thr || mm >= {1'b0, lim})
			r = enc;
		else
			r = meas;
		return r;
	endfunction

	// configuration
	logic [9:0]  duty_thr_q;
	logic [31:0] speed_lim_q, spt_q, radius_q, rob_q;
	logic [15:0] tick_q;
	logic [19:0] step_lim_q;

	// state
	state_t state_q, state_nx;
	op_t    op_q, op_nx;
	logic [COUNT_WIDTH-1:0] last_l_q, last_r_q, cur_l_q, cur_r_q;
	logic signed [31:0] pose_x_q, pose_y_q, pose_h_q, held_l_q, held_r_q;
	logic signed [31:0] meas_l_q, meas_r_q, enc_l_q;
	logic [9:0]  duty_l_q, duty_r_q;
	logic signed [63:0] v_q, d_q, rate_q, dth_q, dx_q, dy_q, sqx_q, sqy_q;
	logic        accepted_q, out_valid_q;
	logic signed [31:0] o_x_q, o_y_q, o_h_q, o_r_q, o_l_q;
	logic        o_acc_q;

	logic        accept, mul_start, mul_done, trig_start, out_load, step_big, step_ok;
	logic signed [63:0] mul_res;
	mul_req_t    req;
	trig_t       trig;
	logic [COUNT_WIDTH-1:0] dl, dr;
	logic signed [63:0] dl64, dr64, sumw, diffw;
	logic [63:0] dxm, dym, cm, sm, sq_sum;
	logic signed [31:0] enc_r;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = state_q != ST_IDLE;
	assign trig_start = accept && !action;
	assign mul_start  = state_q == ST_GO && (op_q != OP_DX || trig.ready);
	assign out_load   = state_q == ST_DONE && (!out_valid_q || !out_stall);

	assign dl    = cur_l_q - last_l_q;
	assign dr    = cur_r_q - last_r_q;
	assign dl64  = 64'(signed'(dl));
	assign dr64  = 64'(signed'(dr));
	assign sumw  = 64'(held_r_q) + 64'(held_l_q);
	assign diffw = 64'(held_r_q) - 64'(held_l_q);
	assign dxm   = mag64(dx_q);
	assign dym   = mag64(dy_q);
	assign cm    = mag64(64'(trig.cos_v));
	assign sm    = mag64(64'(trig.sin_v));
	assign enc_r = sat32(mul_res);

	assign step_big = (|dxm[63:31]) || (|dym[63:31]);
	assign sq_sum   = sqx_q + sqy_q;
	assign step_ok  = !step_big && (sq_sum < 64'({step_lim_q, 24'd0}));

	always_comb begin
		req = '0;
		case (op_q)
			OP_ENC_L: begin req.a = mag64(dl64); req.b = spt_q; req.neg = dl64[63];
				req.sh = SH_0; end
			OP_ENC_R: begin req.a = mag64(dr64); req.b = spt_q; req.neg = dr64[63];
				req.sh = SH_0; end
			OP_V:     begin req.a = mag64(sumw); req.b = radius_q; req.neg = sumw[63];
				req.sh = SH_17; end
			OP_D:     begin req.a = mag64(v_q); req.b = {16'd0, tick_q}; req.neg = v_q[63];
				req.sh = SH_0; end
			OP_RATE:  begin req.a = mag64(diffw); req.b = rob_q; req.neg = diffw[63];
				req.sh = SH_16; end
			OP_DTH:   begin req.a = mag64(rate_q); req.b = {16'd0, tick_q};
				req.neg = rate_q[63]; req.sh = SH_8; end
			OP_DX:    begin req.a = mag64(d_q); req.b = cm[31:0];
				req.neg = d_q[63] ^ trig.cos_v[33]; req.sh = SH_50; end
			OP_DY:    begin req.a = mag64(d_q); req.b = sm[31:0];
				req.neg = d_q[63] ^ trig.sin_v[33]; req.sh = SH_50; end
			OP_SQX:   begin req.a = dxm; req.b = dxm[31:0]; req.sh = SH_0; end
			OP_SQY:   begin req.a = dym; req.b = dym[31:0]; req.sh = SH_0; end
			default:  req = '0;
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_ENC_L: op_nx = OP_ENC_R;
			OP_ENC_R: op_nx = OP_V;
			OP_V:     op_nx = OP_D;
			OP_D:     op_nx = OP_RATE;
			OP_RATE:  op_nx = OP_DTH;
			OP_DTH:   op_nx = OP_DX;
			OP_DX:    op_nx = OP_DY;
			OP_DY:    op_nx = OP_SQX;
			OP_SQX:   op_nx = OP_SQY;
			default:  op_nx = OP_SQY;
		endcase
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nx = action ? ST_DONE : ST_GO;
			ST_GO:    if (mul_start) state_nx = ST_WAIT;
			ST_WAIT:  if (mul_done) state_nx = (op_q == OP_SQY) ? ST_CHECK : ST_GO;
			ST_CHECK: state_nx = ST_DONE;
			ST_DONE:  if (out_load) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_thr_q  <= 10'd100;
			speed_lim_q <= 32'd851968;
			spt_q       <= 32'd40212;
			radius_q    <= 32'd2829844;
			rob_q       <= 32'd14149;
			tick_q      <= 16'd655;
			step_lim_q  <= 20'd400;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DUTY_THR:  duty_thr_q  <= cfg_data[9:0];
				CFG_SPEED_LIM: speed_lim_q <= cfg_data;
				CFG_SPT:       spt_q       <= cfg_data;
				CFG_RADIUS:    radius_q    <= cfg_data;
				CFG_ROB:       rob_q       <= cfg_data;
				CFG_TICK:      tick_q      <= cfg_data[15:0];
				CFG_STEP_LIM:  step_lim_q  <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ENC_L;
			last_l_q    <= '0;
			last_r_q    <= '0;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			pose_h_q    <= '0;
			held_l_q    <= '0;
			held_r_q    <= '0;
			accepted_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				op_q       <= OP_ENC_L;
				accepted_q <= 1'b0;
				if (action) begin
					pose_x_q <= '0;
					pose_y_q <= '0;
					pose_h_q <= '0;
				end
			end
			if (state_q == ST_WAIT && mul_done) begin
				op_q <= op_nx;
				if (op_q == OP_ENC_R) begin
					held_l_q <= pick(dl == '0, duty_l_q, duty_thr_q, meas_l_q, speed_lim_q,
						enc_l_q);
					held_r_q <= pick(dr == '0, duty_r_q, duty_thr_q, meas_r_q, speed_lim_q,
						enc_r);
					last_l_q <= cur_l_q;
					last_r_q <= cur_r_q;
				end
			end
			if (state_q == ST_CHECK && step_ok) begin
				pose_x_q   <= sat32(64'(pose_x_q) + dx_q);
				pose_y_q   <= sat32(64'(pose_y_q) + dy_q);
				pose_h_q   <= sat32(64'(pose_h_q) + dth_q);
				accepted_q <= 1'b1;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_l_q  <= left_count[COUNT_WIDTH-1:0];
			cur_r_q  <= right_count[COUNT_WIDTH-1:0];
			meas_l_q <= left_measured;
			meas_r_q <= right_measured;
			duty_l_q <= left_duty;
			duty_r_q <= right_duty;
		end
		if (state_q == ST_WAIT && mul_done) begin
			case (op_q)
				OP_ENC_L: enc_l_q <= sat32(mul_res);
				OP_V:     v_q     <= mul_res;
				OP_D:     d_q     <= mul_res;
				OP_RATE:  rate_q  <= mul_res;
				OP_DTH:   dth_q   <= mul_res;
				OP_DX:    dx_q    <= mul_res;
				OP_DY:    dy_q    <= mul_res;
				OP_SQX:   sqx_q   <= mul_res;
				OP_SQY:   sqy_q   <= mul_res;
				default: ;
			endcase
		end
		if (out_load) begin
			o_x_q   <= pose_x_q;
			o_y_q   <= pose_y_q;
			o_h_q   <= pose_h_q;
			o_r_q   <= held_r_q;
			o_l_q   <= held_l_q;
			o_acc_q <= accepted_q;
		end
	end

	ddo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.req    (req),
		.done   (mul_done),
		.result (mul_res)
	);

	ddo_cordic #(
		.TRIG_ITERATIONS (TRIG_ITERATIONS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (trig_start),
		.heading (pose_h_q),
		.trig    (trig)
	);

	assign out_valid     = out_valid_q;
	assign pos_x         = o_x_q;
	assign pos_y         = o_y_q;
	assign heading_out   = o_h_q;
	assign right_rate    = o_r_q;
	assign left_rate     = o_l_q;
	assign step_accepted = o_acc_q;

	`CHK_ALWAYS(a_done_in_wait, mul_done |-> (state_q == ST_WAIT), "product finished outside wait")
	`CHK_ALWAYS(a_accept_small, (state_q == ST_DONE && accepted_q) |-> !step_big, "large step kept")

endmodule
